// File: hw/rtl/dual_wheel_incremental_pid_drive_macros.svh
// Assertion macros for the drive top module.
`ifndef DUAL_WHEEL_INCREMENTAL_PID_DRIVE_MACROS_SVH
`define DUAL_WHEEL_INCREMENTAL_PID_DRIVE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DWPID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define DWPID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/dwpid_pkg.sv
// Shared types, codes and constants of the two-wheel PID drive.
package dwpid_pkg;

	localparam int TICK_BITS = 16;
	localparam int DIV_NUM_BITS = 32;
	localparam int DIV_DEN_BITS = 16;

	localparam logic [2:0] CMD_FORWARD  = 3'd0;
	localparam logic [2:0] CMD_BACKWARD = 3'd1;
	localparam logic [2:0] CMD_LEFT     = 3'd2;
	localparam logic [2:0] CMD_RIGHT    = 3'd3;
	localparam logic [2:0] CMD_STOP     = 3'd4;

	localparam logic [1:0] DIR_STOP     = 2'd0;
	localparam logic [1:0] DIR_FORWARD  = 2'd1;
	localparam logic [1:0] DIR_BACKWARD = 2'd2;

	localparam logic [2:0] REG_KP    = 3'd0;
	localparam logic [2:0] REG_KI    = 3'd1;
	localparam logic [2:0] REG_KD    = 3'd2;
	localparam logic [2:0] REG_SCALE = 3'd3;
	localparam logic [2:0] REG_PWM   = 3'd4;
	localparam logic [2:0] REG_LIMIT = 3'd5;

	localparam logic [15:0] KP_RESET    = 16'd410;
	localparam logic [15:0] KI_RESET    = 16'd15;
	localparam logic [15:0] KD_RESET    = 16'd0;
	localparam logic [15:0] SCALE_RESET = 16'd256;
	localparam logic [15:0] PWM_RESET   = 16'd1000;
	localparam logic [14:0] LIMIT_RESET = 15'd670;

	typedef struct packed {
		logic [15:0] kp_centi;
		logic [15:0] ki_centi;
		logic [15:0] kd_centi;
		logic [15:0] velocity_scale;
		logic [15:0] pwm_max;
		logic [14:0] full_speed_limit;
	} cfg_t;

	typedef struct packed {
		logic [15:0]        duty;
		logic [1:0]         dir;
		logic signed [15:0] speed;
		logic signed [31:0] odometry;
	} lane_res_t;

endpackage

// File: hw/rtl/dual_wheel_incremental_pid_drive.sv
// Two-wheel PID drive: register port, wheel lanes and result register.
// A motion command passes each lane's measurement, PID and PWM steps, including the serial
// division by the limit in each lane; stop and unknown codes skip the PID and the division.
// A new item is taken only after the last one's results are registered; the input stays stalled
// until the result register is free to take the lanes' results.
// Reset restores the register reset values and clears the odometry totals and PID state.
`include "dual_wheel_incremental_pid_drive_macros.svh"
module dual_wheel_incremental_pid_drive #(
	parameter int TICK_BITS = dwpid_pkg::TICK_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [4:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  cmd,
	input  logic signed [15:0]          speed,
	input  logic signed [TICK_BITS-1:0] left_ticks,
	input  logic signed [TICK_BITS-1:0] right_ticks,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [15:0]                 left_duty,
	output logic [1:0]                  left_dir,
	output logic [15:0]                 right_duty,
	output logic [1:0]                  right_dir,
	output logic signed [15:0]          left_speed,
	output logic signed [15:0]          right_speed,
	output logic signed [31:0]          left_odometry,
	output logic signed [31:0]          right_odometry
);

	localparam int DW = TICK_BITS + 1;

	dwpid_pkg::cfg_t      cfg_q;
	dwpid_pkg::lane_res_t lres, rres;
	logic                 busy_q, ldone_q, rdone_q, out_valid_q;
	logic                 lane_start, run, ldone, rdone, finish;
	logic signed [DW-1:0] ldelta, rdelta;
	logic signed [16:0]   spd, ltgt, rtgt;
	logic                 in_xfer;

	assign pready   = 1'b1;
	assign in_stall = busy_q;
	assign in_xfer  = in_valid && !busy_q;
	assign lane_start = in_xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_centi         <= dwpid_pkg::KP_RESET;
			cfg_q.ki_centi         <= dwpid_pkg::KI_RESET;
			cfg_q.kd_centi         <= dwpid_pkg::KD_RESET;
			cfg_q.velocity_scale   <= dwpid_pkg::SCALE_RESET;
			cfg_q.pwm_max          <= dwpid_pkg::PWM_RESET;
			cfg_q.full_speed_limit <= dwpid_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[4:2])
				dwpid_pkg::REG_KP:    cfg_q.kp_centi         <= pwdata[15:0];
				dwpid_pkg::REG_KI:    cfg_q.ki_centi         <= pwdata[15:0];
				dwpid_pkg::REG_KD:    cfg_q.kd_centi         <= pwdata[15:0];
				dwpid_pkg::REG_SCALE: cfg_q.velocity_scale   <= pwdata[15:0];
				dwpid_pkg::REG_PWM:   cfg_q.pwm_max          <= pwdata[15:0];
				dwpid_pkg::REG_LIMIT: cfg_q.full_speed_limit <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			dwpid_pkg::REG_KP:    prdata = 32'(cfg_q.kp_centi);
			dwpid_pkg::REG_KI:    prdata = 32'(cfg_q.ki_centi);
			dwpid_pkg::REG_KD:    prdata = 32'(cfg_q.kd_centi);
			dwpid_pkg::REG_SCALE: prdata = 32'(cfg_q.velocity_scale);
			dwpid_pkg::REG_PWM:   prdata = 32'(cfg_q.pwm_max);
			dwpid_pkg::REG_LIMIT: prdata = 32'(cfg_q.full_speed_limit);
			default:              prdata = '0;
		endcase
	end

	// The left encoder counts the other way round, so its delta is negated.
	assign ldelta = -DW'(left_ticks);
	assign rdelta = DW'(right_ticks);
	assign spd    = 17'(speed);
	assign run    = cmd <= dwpid_pkg::CMD_RIGHT;
	assign ltgt   = (cmd == dwpid_pkg::CMD_BACKWARD || cmd == dwpid_pkg::CMD_LEFT) ? -spd : spd;
	assign rtgt   = (cmd == dwpid_pkg::CMD_BACKWARD || cmd == dwpid_pkg::CMD_RIGHT) ? -spd : spd;

	dwpid_lane #(.TICK_BITS(TICK_BITS)) u_left (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.run    (run),
		.delta  (ldelta),
		.target (ltgt),
		.cfg    (cfg_q),
		.done   (ldone),
		.res    (lres)
	);

	dwpid_lane #(.TICK_BITS(TICK_BITS)) u_right (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lane_start),
		.run    (run),
		.delta  (rdelta),
		.target (rtgt),
		.cfg    (cfg_q),
		.done   (rdone),
		.res    (rres)
	);

	// Both lanes must have finished and the result register must be free.
	assign finish = (ldone_q || ldone) && (rdone_q || rdone) && busy_q
	                && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ldone_q     <= 1'b0;
			rdone_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_xfer) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q      <= 1'b0;
				ldone_q     <= 1'b0;
				rdone_q     <= 1'b0;
				out_valid_q <= 1'b1;
			end else begin
				if (ldone) ldone_q <= 1'b1;
				if (rdone) rdone_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			left_duty      <= lres.duty;
			left_dir       <= lres.dir;
			left_speed     <= lres.speed;
			left_odometry  <= lres.odometry;
			right_duty     <= rres.duty;
			right_dir      <= rres.dir;
			right_speed    <= rres.speed;
			right_odometry <= rres.odometry;
		end
	end

	assign out_valid = out_valid_q;

	`DWPID_ASSERT_NEXT(a_take_busy, in_valid && !in_stall, busy_q, "transfer did not start the lanes")
	`DWPID_ASSERT_NOW(a_done_busy, ldone_q || rdone_q, busy_q, "lane finished while idle")
	`DWPID_ASSERT_NOW(a_stop_duty, out_valid && left_dir == dwpid_pkg::DIR_STOP, left_duty == 16'd0, "left duty without direction")

endmodule

// File: hw/rtl/dwpid_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module dwpid_div #(
	parameter int NUM_BITS = dwpid_pkg::DIV_NUM_BITS,
	parameter int DEN_BITS = dwpid_pkg::DIV_DEN_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] dividend,
	input  logic [DEN_BITS-1:0] divisor,
	output logic                done,
	output logic [NUM_BITS-1:0] quotient
);

	localparam int CW = $clog2(NUM_BITS) + 1;

	logic                busy_q;
	logic [CW-1:0]       cnt_q;
	logic [NUM_BITS-1:0] num_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [DEN_BITS-1:0] den_q;
	logic [DEN_BITS:0]   trial;
	logic                fit;

	assign trial = {rem_q, num_q[NUM_BITS-1]};
	assign fit   = trial >= {1'b0, den_q};
	assign quotient = num_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_BITS);
				num_q  <= dividend;
				den_q  <= divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q <= fit ? DEN_BITS'(trial - {1'b0, den_q}) : DEN_BITS'(trial);
				num_q <= {num_q[NUM_BITS-2:0], fit};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

// File: hw/rtl/dwpid_lane.sv
// One wheel: speed measurement, odometry, incremental PID and PWM scaling.
module dwpid_lane #(
	parameter int TICK_BITS = dwpid_pkg::TICK_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    run,
	input  logic signed [TICK_BITS:0] delta,
	input  logic signed [16:0]      target,
	input  dwpid_pkg::cfg_t         cfg,
	output logic                    done,
	output dwpid_pkg::lane_res_t    res
);

	localparam int DW  = TICK_BITS + 1;
	localparam int MA  = (DW > 19) ? DW : 19;
	localparam int MB  = 17;
	localparam int PW  = MA + MB;
	localparam int SW  = 40;
	localparam int ACW = SW + 2;
	localparam int NB  = dwpid_pkg::DIV_NUM_BITS;
	localparam int DB  = dwpid_pkg::DIV_DEN_BITS;
	// ceil(2^29 / 100); exact for every magnitude below 2^22.
	localparam logic [22:0] RECIP_100 = 23'd5368710;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MMUL, ST_MEAS, ST_ERR, ST_P, ST_I, ST_D, ST_ACC,
		ST_D1, ST_PM, ST_D2, ST_W2, ST_DONE
	} st_t;

	st_t state_q;

	logic signed [DW-1:0]  delta_q;
	logic signed [16:0]    target_q;
	logic                  run_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [SW-1:0]  sum_q;
	logic signed [15:0]    meas_q;
	logic signed [31:0]    total_q;
	logic signed [16:0]    e_q, e1_q, e2_q;
	logic signed [23:0]    accum_q;
	logic [14:0]           omag_q;
	logic [15:0]           duty_q;
	logic [1:0]            dir_q;

	logic signed [MA-1:0]  mul_a;
	logic signed [MB-1:0]  mul_b;
	logic signed [PW-1:0]  mul_p;
	logic signed [PW:0]    rnd;
	logic signed [PW:0]    shq;
	logic signed [15:0]    meas_sat;
	logic signed [17:0]    diff;
	logic signed [16:0]    e_sat;
	logic [14:0]           lim;
	logic [21:0]           lim100;
	logic signed [ACW-1:0] nacc;
	logic signed [ACW-1:0] hl;
	logic signed [23:0]    acc_clamp;
	logic [23:0]           amag;
	logic [46:0]           rprod;
	logic signed [63:0]    delta_ext;
	logic                  div_start;
	logic [NB-1:0]         div_num;
	logic [DB-1:0]         div_den;
	logic                  div_done;
	logic [NB-1:0]         div_quo;
	logic [15:0]           pwm_mag;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MMUL: begin
				mul_a = MA'(delta_q);
				mul_b = $signed({1'b0, cfg.velocity_scale});
			end
			ST_P: begin
				mul_a = MA'(e_q) - MA'(e1_q);
				mul_b = $signed({1'b0, cfg.kp_centi});
			end
			ST_I: begin
				mul_a = MA'(e_q);
				mul_b = $signed({1'b0, cfg.ki_centi});
			end
			ST_D: begin
				mul_a = MA'(e_q) - (MA'(e1_q) <<< 1) + MA'(e2_q);
				mul_b = $signed({1'b0, cfg.kd_centi});
			end
			ST_PM: begin
				mul_a = MA'($signed({1'b0, omag_q}));
				mul_b = $signed({1'b0, cfg.pwm_max});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// Division by 256 truncates toward zero, so negative products are biased first.
	assign rnd = (PW+1)'(prod_q) + (prod_q[PW-1] ? (PW+1)'(255) : (PW+1)'(0));
	assign shq = rnd >>> 8;
	assign meas_sat = (shq > (PW+1)'(32'sd32767))  ? 16'sd32767 :
	                  (shq < (PW+1)'(-32'sd32768)) ? -16'sd32768 : 16'(shq);

	assign diff  = 18'(target_q) - 18'(meas_q);
	assign e_sat = (diff > 18'sd65535)  ? 17'sd65535 :
	               (diff < -18'sd65536) ? -17'sd65536 : 17'(diff);

	assign lim    = (cfg.full_speed_limit == '0) ? 15'd1 : cfg.full_speed_limit;
	assign lim100 = (22'(lim) << 6) + (22'(lim) << 5) + (22'(lim) << 2);
	assign hl     = ACW'($signed({1'b0, lim100}));
	assign nacc   = ACW'(accum_q) + ACW'(sum_q) + ACW'(prod_q);
	assign acc_clamp = (nacc > hl) ? 24'(hl) : (nacc < -hl) ? 24'(-hl) : 24'(nacc);

	// The accumulator magnitude is divided by 100 with a reciprocal multiply.
	assign amag      = accum_q[23] ? 24'(-accum_q) : 24'(accum_q);
	assign rprod     = 47'(amag) * 47'(RECIP_100);
	assign delta_ext = 64'(delta_q);

	assign div_start = (state_q == ST_D2);
	assign div_num   = NB'(prod_q[31:0]);
	assign div_den   = DB'(lim);
	assign pwm_mag   = (div_quo > NB'(cfg.pwm_max)) ? cfg.pwm_max : div_quo[15:0];

	dwpid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
			total_q <= '0;
			accum_q <= '0;
			e1_q    <= '0;
			e2_q    <= '0;
			duty_q  <= '0;
			dir_q   <= dwpid_pkg::DIR_STOP;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						delta_q  <= delta;
						target_q <= target;
						run_q    <= run;
						state_q  <= ST_MMUL;
					end
				end
				ST_MMUL: begin
					prod_q  <= mul_p;
					state_q <= ST_MEAS;
				end
				ST_MEAS: begin
					meas_q  <= meas_sat;
					total_q <= total_q + delta_ext[31:0];
					if (run_q) begin
						state_q <= ST_ERR;
					end else begin
						duty_q  <= '0;
						dir_q   <= dwpid_pkg::DIR_STOP;
						state_q <= ST_DONE;
					end
				end
				ST_ERR: begin
					e_q     <= e_sat;
					state_q <= ST_P;
				end
				ST_P: begin
					prod_q  <= mul_p;
					sum_q   <= '0;
					state_q <= ST_I;
				end
				ST_I: begin
					sum_q   <= sum_q + SW'(prod_q);
					prod_q  <= mul_p;
					state_q <= ST_D;
				end
				ST_D: begin
					sum_q   <= sum_q + SW'(prod_q);
					prod_q  <= mul_p;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					accum_q <= acc_clamp;
					e2_q    <= e1_q;
					e1_q    <= e_q;
					state_q <= ST_D1;
				end
				ST_D1: begin
					omag_q  <= 15'(rprod >> 29);
					state_q <= ST_PM;
				end
				ST_PM: begin
					prod_q  <= mul_p;
					state_q <= ST_D2;
				end
				ST_D2: state_q <= ST_W2;
				ST_W2: begin
					if (div_done) begin
						duty_q <= pwm_mag;
						if (pwm_mag == '0) begin
							dir_q <= dwpid_pkg::DIR_STOP;
						end else if (accum_q[23]) begin
							dir_q <= dwpid_pkg::DIR_BACKWARD;
						end else begin
							dir_q <= dwpid_pkg::DIR_FORWARD;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.duty     = duty_q;
	assign res.dir      = dir_q;
	assign res.speed    = meas_q;
	assign res.odometry = total_q;

endmodule

// File: tb/dwpid_checker.sv
// Checker for the two-wheel PID drive: watches both channels, predicts results and compares them.
module dwpid_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic signed [15:0] speed,
	input  logic signed [15:0] left_ticks,
	input  logic signed [15:0] right_ticks,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [15:0]        left_duty,
	input  logic [1:0]         left_dir,
	input  logic [15:0]        right_duty,
	input  logic [1:0]         right_dir,
	input  logic signed [15:0] left_speed,
	input  logic signed [15:0] right_speed,
	input  logic signed [31:0] left_odometry,
	input  logic signed [31:0] right_odometry,
	output int                 fail_count,
	output int                 pending,
	output int                 result_count
);

	typedef struct {
		logic [15:0] l_duty;
		logic [1:0]  l_dir;
		logic [15:0] r_duty;
		logic [1:0]  r_dir;
		logic [15:0] l_speed;
		logic [15:0] r_speed;
		logic [31:0] l_odo;
		logic [31:0] r_odo;
	} drive_result_t;

	typedef struct {
		longint accum;
		longint e1;
		longint e2;
	} wheel_state_t;

	drive_result_t expected_results[$];
	wheel_state_t  lw, rw;
	logic [15:0]   kp, ki, kd, vscale, pmax;
	logic [14:0]   flimit;
	logic [31:0]   ltotal, rtotal;

	assign pending = expected_results.size();

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint wheel_speed(longint delta);
		return clip((delta * longint'(vscale)) / 256, -32768, 32767);
	endfunction

	// Advances one wheel's PID and returns the signed PWM compare value.
	function automatic longint pid_step(ref wheel_state_t w, input longint target,
			input longint meas);
		longint lim, e, d, o, pwm;
		lim = (flimit == 0) ? 1 : longint'(flimit);
		e = clip(target - meas, -65536, 65535);
		d = longint'(kp) * (e - w.e1) + longint'(ki) * e
			+ longint'(kd) * (e - 2 * w.e1 + w.e2);
		w.accum = clip(w.accum + d, -100 * lim, 100 * lim);
		w.e2 = w.e1;
		w.e1 = e;
		o = w.accum / 100;
		pwm = (o * longint'(pmax)) / lim;
		return clip(pwm, -longint'(pmax), longint'(pmax));
	endfunction

	function automatic void to_drive(longint pwm, output logic [15:0] duty,
			output logic [1:0] dir);
		if (pwm > 0) begin
			dir = dwpid_pkg::DIR_FORWARD;
			duty = pwm[15:0];
		end else if (pwm < 0) begin
			dir = dwpid_pkg::DIR_BACKWARD;
			duty = 16'((-pwm));
		end else begin
			dir = dwpid_pkg::DIR_STOP;
			duty = '0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_result_t exp_r, got;
		longint ld, rd, lm, rm, sp, lt, rt;
		if (!arst_n) begin
			kp = dwpid_pkg::KP_RESET; ki = dwpid_pkg::KI_RESET; kd = dwpid_pkg::KD_RESET;
			vscale = dwpid_pkg::SCALE_RESET; pmax = dwpid_pkg::PWM_RESET;
			flimit = dwpid_pkg::LIMIT_RESET;
			lw = '{0, 0, 0};
			rw = '{0, 0, 0};
			ltotal = '0;
			rtotal = '0;
			expected_results.delete();
			fail_count = 0;
			result_count = 0;
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[4:2])
					dwpid_pkg::REG_KP:    kp = pwdata[15:0];
					dwpid_pkg::REG_KI:    ki = pwdata[15:0];
					dwpid_pkg::REG_KD:    kd = pwdata[15:0];
					dwpid_pkg::REG_SCALE: vscale = pwdata[15:0];
					dwpid_pkg::REG_PWM:   pmax = pwdata[15:0];
					dwpid_pkg::REG_LIMIT: flimit = pwdata[14:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				ld = -longint'(left_ticks);
				rd = longint'(right_ticks);
				lm = wheel_speed(ld);
				rm = wheel_speed(rd);
				ltotal += 32'(ld);
				rtotal += 32'(rd);
				exp_r.l_speed = lm[15:0];
				exp_r.r_speed = rm[15:0];
				exp_r.l_odo = ltotal;
				exp_r.r_odo = rtotal;
				exp_r.l_duty = '0; exp_r.l_dir = dwpid_pkg::DIR_STOP;
				exp_r.r_duty = '0; exp_r.r_dir = dwpid_pkg::DIR_STOP;
				if (cmd <= dwpid_pkg::CMD_RIGHT) begin
					sp = longint'(speed);
					lt = (cmd == dwpid_pkg::CMD_BACKWARD || cmd == dwpid_pkg::CMD_LEFT)
						? -sp : sp;
					rt = (cmd == dwpid_pkg::CMD_BACKWARD || cmd == dwpid_pkg::CMD_RIGHT)
						? -sp : sp;
					to_drive(pid_step(lw, lt, lm), exp_r.l_duty, exp_r.l_dir);
					to_drive(pid_step(rw, rt, rm), exp_r.r_duty, exp_r.r_dir);
				end
				expected_results.push_back(exp_r);
			end
			if (out_valid && !out_stall) begin
				got = '{left_duty, left_dir, right_duty, right_dir, left_speed,
					right_speed, left_odometry, right_odometry};
				result_count++;
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("checker: result transfer with nothing expected");
				end else begin
					exp_r = expected_results.pop_front();
					if (got != exp_r) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"checker: mismatch at result %0d: expected duty %0d/%0d ",
								"dir %0d/%0d speed %0d/%0d odo %0d/%0d, got duty %0d/%0d ",
								"dir %0d/%0d speed %0d/%0d odo %0d/%0d"}, result_count,
								exp_r.l_duty, exp_r.r_duty, exp_r.l_dir, exp_r.r_dir,
								$signed(exp_r.l_speed), $signed(exp_r.r_speed),
								$signed(exp_r.l_odo), $signed(exp_r.r_odo),
								got.l_duty, got.r_duty, got.l_dir, got.r_dir,
								$signed(got.l_speed), $signed(got.r_speed),
								$signed(got.l_odo), $signed(got.r_odo));
					end
				end
			end
		end
	end
endmodule

// File: tb/tb_top.sv
// Testbench top for the two-wheel PID drive: stimulus, register writes and verdict.
module tb_top;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               psel = 0, penable = 0, pwrite = 0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 0, in_stall;
	logic [2:0]         cmd = '0;
	logic signed [15:0] speed = '0, left_ticks = '0, right_ticks = '0;
	logic               out_valid, out_stall = 0;
	logic [15:0]        left_duty, right_duty;
	logic [1:0]         left_dir, right_dir;
	logic signed [15:0] left_speed, right_speed;
	logic signed [31:0] left_odometry, right_odometry;
	int                 fail_count, pending, result_count;
	bit                 hold_off = 0;
	int                 sent = 0;

	always #5 clk = ~clk;

	dual_wheel_incremental_pid_drive dut (.*);

	dwpid_checker checker_i (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.in_valid, .in_stall, .cmd, .speed, .left_ticks, .right_ticks,
		.out_valid, .out_stall, .left_duty, .left_dir, .right_duty, .right_dir,
		.left_speed, .right_speed, .left_odometry, .right_odometry,
		.fail_count, .pending, .result_count
	);

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic load_gains(input logic [15:0] p, i, d, sc, pw, input logic [14:0] lim);
		write_reg(dwpid_pkg::REG_KP, p);
		write_reg(dwpid_pkg::REG_KI, i);
		write_reg(dwpid_pkg::REG_KD, d);
		write_reg(dwpid_pkg::REG_SCALE, sc);
		write_reg(dwpid_pkg::REG_PWM, pw);
		write_reg(dwpid_pkg::REG_LIMIT, lim);
	endtask

	// One input transfer, preceded by a random gap unless told otherwise.
	// Valid stays high after the transfer; drain lowers it, and the next call does so only before a gap.
	task automatic send_tick(input logic [2:0] c, input logic [15:0] s, lt, rt,
			input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 15) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1; cmd <= c; speed <= s; left_ticks <= lt; right_ticks <= rt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	function automatic logic [15:0] rnd_val();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'(int'($urandom_range(0, 40)) - 20);
			default: return 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
		endcase
	endfunction

	// Mostly motion commands, with stops and the unused codes mixed in.
	task automatic random_phase(input int n);
		logic [2:0] c;
		logic [15:0] s;
		repeat (n) begin
			c = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
				: 3'($urandom_range(0, 3));
			s = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535))
				: 16'(int'($urandom_range(0, 1400)) - 700);
			send_tick(c, s, rnd_val(), rnd_val(), $urandom_range(0, 4) != 0);
		end
	endtask

	// Receiver: random stall per result, one long hold-off on request.
	always begin
		int wait_cycles;
		@(negedge clk);
		if (hold_off) begin
			out_stall <= 1;
			repeat (400) @(negedge clk);
			hold_off = 0;
		end else if (out_valid) begin
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
			if (wait_cycles != 0) begin
				out_stall <= 1;
				repeat (wait_cycles) @(negedge clk);
			end
			out_stall <= 0;
			while (out_valid) @(negedge clk);
		end else begin
			out_stall <= $urandom_range(0, 1);
		end
	end

	initial begin
		#3000000;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1;
		// Directed: field extremes, every command, stop and unused codes.
		send_tick(dwpid_pkg::CMD_FORWARD, 16'sd300, 16'sd0, 16'sd0, 0);
		send_tick(dwpid_pkg::CMD_FORWARD, 16'h7fff, 16'h8000, 16'h7fff, 0);
		send_tick(dwpid_pkg::CMD_BACKWARD, 16'h8000, 16'h7fff, 16'h8000, 0);
		send_tick(dwpid_pkg::CMD_LEFT, 16'sd500, 16'hffff, 16'sd1, 0);
		send_tick(dwpid_pkg::CMD_RIGHT, 16'sd500, 16'sd1, 16'hffff, 0);
		send_tick(dwpid_pkg::CMD_STOP, 16'sd100, 16'sd20, 16'sd20, 0);
		send_tick(3'd5, 16'hffff, 16'hffff, 16'hffff, 0);
		send_tick(3'd7, 16'sd0, 16'h5555, 16'haaaa, 0);
		send_tick(dwpid_pkg::CMD_FORWARD, 16'sd200, 16'sd0, 16'sd0, 1);
		send_tick(dwpid_pkg::CMD_BACKWARD, 16'sd0, 16'sd0, 16'sd0, 1);
		drain();
		load_gains(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 15'h7fff);
		send_tick(dwpid_pkg::CMD_FORWARD, 16'h7fff, 16'h8000, 16'h8000, 0);
		send_tick(dwpid_pkg::CMD_LEFT, 16'h8000, 16'h7fff, 16'h7fff, 0);
		send_tick(dwpid_pkg::CMD_RIGHT, 16'h7fff, 16'sd0, 16'sd0, 0);
		drain();
		// Zero limit behaves as one; zero scale and gains.
		load_gains(16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 15'd0);
		send_tick(dwpid_pkg::CMD_FORWARD, 16'sd50, 16'sd10, 16'sd10, 0);
		send_tick(dwpid_pkg::CMD_BACKWARD, 16'sd50, 16'sd10, 16'sd10, 0);
		drain();
		load_gains(16'd200, 16'd40, 16'd50, 16'd256, 16'd1000, 15'd670);
		send_tick(dwpid_pkg::CMD_FORWARD, 16'sd400, 16'sd0, 16'sd0, 0);
		send_tick(dwpid_pkg::CMD_FORWARD, 16'sd400, -16'sd100, 16'sd100, 0);
		drain();
		// Long receiver hold-off while the sender keeps offering transfers.
		hold_off = 1;
		random_phase(20);
		drain();
		random_phase(200);
		drain();
		load_gains(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 300)),
			16'($urandom_range(0, 500)), 16'($urandom_range(0, 1024)),
			16'($urandom_range(1, 4000)), 15'($urandom_range(1, 2000)));
		random_phase(200);
		drain();
		load_gains(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
			16'($urandom_range(1, 65535)), 15'($urandom_range(1, 32767)));
		random_phase(200);
		drain();
		$display("tb_top: %0d input transfers, %0d results checked, several register settings",
			sent, result_count);
		$display("tb_top: including gain and limit extremes, stop and unused commands");
		if (fail_count == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end
endmodule
